// ----- rtl/msp_pkg.sv -----
// ----------------------------------------------------------------------------
// msp_pkg
// Shared types and constants for the multicore slot placement block.
// ----------------------------------------------------------------------------
package msp_pkg;

  localparam int MAX_CORES = 16;
  localparam int MAX_SLOTS = 32;
  localparam int CORE_W    = $clog2(MAX_CORES);
  localparam int SLOT_W    = $clog2(MAX_SLOTS);
  localparam int CNT_W     = $clog2(MAX_CORES + 1);
  localparam int SCNT_W    = $clog2(MAX_SLOTS + 1);
  localparam int LEN_W     = 22;
  localparam int SPARE_W   = 25;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_NOCORES = 2'd1;
  localparam logic [1:0] ST_OVERLAP = 2'd2;
  localparam logic [1:0] ST_BADCORE = 2'd3;

  localparam logic [1:0] REG_CORES = 2'd0;
  localparam logic [1:0] REG_SLOT  = 2'd1;
  localparam logic [1:0] REG_SLOTS = 2'd2;

  typedef enum logic [3:0] {
    S_IDLE,
    S_RES_RD,
    S_RES_CHK,
    S_RES_DIV,
    S_PL_RD,
    S_PL_SCAN,
    S_PL_MUL,
    S_PL_CLASS,
    S_PL_PICK,
    S_OUT
  } state_t;

endpackage

// ----- rtl/msp_ram.sv -----
// ----------------------------------------------------------------------------
// msp_ram
// Generic single-port synchronous RAM with registered read.
// ----------------------------------------------------------------------------
module msp_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

// ----- rtl/multicore_slot_placement_core.sv -----
// ----------------------------------------------------------------------------
// multicore_slot_placement_core
// Busy-slot bitmap per core with reservation and best-fit core placement.
// ----------------------------------------------------------------------------
// The slot maps of all cores sit in one 16-entry RAM. After reset a clearing
// pass writes zero to every entry, one per cycle, so the block takes no
// request until the pass is done. A reserve request runs a 21-step bit-serial
// division of the execution time by the slot time, then a read and a
// check-and-write of the core's map. A place request takes each core in use
// in turn, reading, finding, scaling and classifying its free run, then picks
// one core at a time by a scan over registered per-core lengths; a stall on
// the result side holds it. A request refused on its fields alone answers
// straight from the idle state, in the cycle after it is taken. One result
// goes out per chosen core, and a new request is only taken once the last
// result of the previous one has left.
module multicore_slot_placement_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // action[0], start_slot[5:1], exec_time[26:6], cores_wanted[31:27],
  // core_select[35:32], zero[39:36]
  input  logic [39:0] in_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  // core_id[3:0], spare_time[28:4], status[30:29], zero[31]
  output logic [31:0] out_tdata,
  output logic        out_tlast,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [3:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  import msp_pkg::*;

  // configuration
  logic [4:0]  cores_r;
  logic [15:0] slot_time_r;
  logic [5:0]  slots_r;
  logic [1:0]  cfg_idx;
  logic        cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_idx    = cfg_paddr[3:2];
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cores_r     <= 5'd16;
      slot_time_r <= 16'd1;
      slots_r     <= 6'd32;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_CORES: cores_r     <= cfg_pwdata[4:0];
        REG_SLOT:  slot_time_r <= cfg_pwdata[15:0];
        REG_SLOTS: slots_r     <= cfg_pwdata[5:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_CORES: cfg_prdata = {27'd0, cores_r};
      REG_SLOT:  cfg_prdata = {16'd0, slot_time_r};
      REG_SLOTS: cfg_prdata = {26'd0, slots_r};
      default:   cfg_prdata = 32'd0;
    endcase
  end

  // effective limits
  logic [CNT_W-1:0]  eff_c;
  logic [SCNT_W-1:0] eff_h;
  assign eff_c = (cores_r > 5'(MAX_CORES)) ? CNT_W'(MAX_CORES) : CNT_W'(cores_r);
  assign eff_h = (slots_r > 6'(MAX_SLOTS)) ? SCNT_W'(MAX_SLOTS) : SCNT_W'(slots_r);

  // request fields
  logic              f_action;
  logic [4:0]        f_start;
  logic [20:0]       f_exec;
  logic [4:0]        f_want;
  logic [3:0]        f_core;
  assign f_action = in_tdata[0];
  assign f_start  = in_tdata[5:1];
  assign f_exec   = in_tdata[26:6];
  assign f_want   = in_tdata[31:27];
  assign f_core   = in_tdata[35:32];

  // registers
  state_t             state_r, state_nxt;
  logic               clr_r, clr_nxt;
  logic [CORE_W-1:0]  clr_idx_r, clr_idx_nxt;
  logic [4:0]         start_r, start_nxt;
  logic [20:0]        exec_r, exec_nxt;
  logic [4:0]         want_r, want_nxt;
  logic [CNT_W-1:0]   core_r, core_nxt;
  logic [MAX_SLOTS-1:0] word_r, word_nxt;
  logic [SCNT_W-1:0]  run_r, run_nxt;
  logic [LEN_W-1:0]   len_r, len_nxt;
  logic [LEN_W-1:0]   lens_r [MAX_CORES];
  logic [MAX_CORES-1:0] fit_r, unc_r, used_r;
  logic [MAX_CORES-1:0] fit_nxt, unc_nxt, used_nxt;
  logic [CNT_W-1:0]   nfit_r, nfit_nxt, nunc_r, nunc_nxt;
  logic [CNT_W-1:0]   k_r, k_nxt;
  logic [SPARE_W-1:0] spare_r, spare_nxt;
  logic [20:0]        quo_r, quo_nxt;
  logic [15:0]        rem_r, rem_nxt;
  logic [4:0]         dstep_r, dstep_nxt;
  logic [CNT_W-1:0]   pidx_r, pidx_nxt;
  logic               pfound_r, pfound_nxt;
  logic [LEN_W-1:0]   pbest_r, pbest_nxt;
  logic [CORE_W-1:0]  pbi_r, pbi_nxt;
  logic               oval_r, oval_nxt;
  logic [3:0]         ocore_r, ocore_nxt;
  logic [SPARE_W-1:0] ospare_r, ospare_nxt;
  logic [1:0]         ostat_r, ostat_nxt;
  logic               olast_r, olast_nxt;

  // memory
  logic              ram_we;
  logic [CORE_W-1:0] ram_addr;
  logic [MAX_SLOTS-1:0] ram_wdata, ram_rdata;

  msp_ram #(.WIDTH(MAX_SLOTS), .DEPTH(MAX_CORES)) u_map (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  // reserve range mask from start and slot count
  logic [SCNT_W:0]   res_end;
  logic [MAX_SLOTS-1:0] res_mask;
  logic [5:0]        nslots;
  always_comb begin
    if (exec_r == 21'd0) begin
      nslots = 6'd0;
    end else if (slot_time_r == 16'd0) begin
      nslots = 6'(MAX_SLOTS);
    end else begin
      nslots = (quo_r > 21'(MAX_SLOTS)) ? 6'(MAX_SLOTS) : 6'(quo_r);
    end
    res_end = (SCNT_W+1)'(start_r) + (SCNT_W+1)'(nslots);
    if (res_end > (SCNT_W+1)'(eff_h)) begin
      res_end = (SCNT_W+1)'(eff_h);
    end
    for (int j = 0; j < MAX_SLOTS; j++) begin
      res_mask[j] = ((SCNT_W+1)'(j) >= (SCNT_W+1)'(start_r)) &&
                    ((SCNT_W+1)'(j) < res_end);
    end
  end

  logic [16:0] div_trial;
  logic [16:0] rem_sh;
  logic [LEN_W-1:0] run_len;
  logic        in_acc;
  logic        out_acc;
  assign in_acc  = in_tvalid && in_tready;
  assign out_acc = out_tvalid && out_tready;
  assign in_tready = (state_r == S_IDLE) && !clr_r && !oval_r;

  always_comb begin
    state_nxt   = state_r;
    clr_nxt     = clr_r;
    clr_idx_nxt = clr_idx_r;
    start_nxt   = start_r;
    exec_nxt    = exec_r;
    want_nxt    = want_r;
    core_nxt    = core_r;
    word_nxt    = word_r;
    run_nxt     = run_r;
    len_nxt     = len_r;
    fit_nxt     = fit_r;
    unc_nxt     = unc_r;
    used_nxt    = used_r;
    nfit_nxt    = nfit_r;
    nunc_nxt    = nunc_r;
    k_nxt       = k_r;
    spare_nxt   = spare_r;
    quo_nxt     = quo_r;
    rem_nxt     = rem_r;
    dstep_nxt   = dstep_r;
    pidx_nxt    = pidx_r;
    pfound_nxt  = pfound_r;
    pbest_nxt   = pbest_r;
    pbi_nxt     = pbi_r;
    oval_nxt    = oval_r;
    ocore_nxt   = ocore_r;
    ospare_nxt  = ospare_r;
    ostat_nxt   = ostat_r;
    olast_nxt   = olast_r;
    ram_we      = 1'b0;
    ram_addr    = core_r[CORE_W-1:0];
    ram_wdata   = word_r;
    rem_sh      = {rem_r, quo_r[20]};
    div_trial   = rem_sh - {1'b0, slot_time_r};
    run_len     = LEN_W'(run_r);

    if (out_acc) begin
      oval_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (clr_r) begin
          ram_we    = 1'b1;
          ram_addr  = clr_idx_r;
          ram_wdata = '0;
          clr_idx_nxt = clr_idx_r + 1'b1;
          if (clr_idx_r == CORE_W'(MAX_CORES - 1)) begin
            clr_nxt = 1'b0;
          end
        end else if (in_acc) begin
          start_nxt = f_start;
          exec_nxt  = f_exec;
          want_nxt  = f_want;
          if (f_action) begin
            if (CNT_W'(f_core) >= eff_c) begin
              ocore_nxt = '0; ospare_nxt = '0; ostat_nxt = ST_BADCORE;
              olast_nxt = 1'b1; oval_nxt = 1'b1;
            end else begin
              core_nxt  = CNT_W'(f_core);
              // exec divided bit-serially by slot_time, rounded up afterwards
              quo_nxt   = f_exec;
              rem_nxt   = '0;
              dstep_nxt = '0;
              state_nxt = S_RES_DIV;
            end
          end else if (CNT_W'(f_want) > eff_c) begin
            ocore_nxt = '0; ospare_nxt = '0; ostat_nxt = ST_NOCORES;
            olast_nxt = 1'b1; oval_nxt = 1'b1;
          end else begin
            core_nxt = '0;
            fit_nxt  = '0;
            unc_nxt  = '0;
            used_nxt = '0;
            nfit_nxt = '0;
            nunc_nxt = '0;
            state_nxt = (eff_c == '0) ? S_PL_CLASS : S_PL_RD;
          end
        end
      end

      S_RES_DIV: begin
        // restoring division: quotient in quo_r, remainder in rem_r
        if (!div_trial[16]) begin
          rem_nxt = div_trial[15:0];
          quo_nxt = {quo_r[19:0], 1'b1};
        end else begin
          rem_nxt = rem_sh[15:0];
          quo_nxt = {quo_r[19:0], 1'b0};
        end
        dstep_nxt = dstep_r + 1'b1;
        if (dstep_r == 5'd20) begin
          state_nxt = S_RES_RD;
        end
      end

      S_RES_RD: begin
        // round up
        if (rem_r != '0) begin
          quo_nxt = quo_r + 1'b1;
        end
        state_nxt = S_RES_CHK;
      end

      S_RES_CHK: begin
        ocore_nxt = '0; ospare_nxt = '0; olast_nxt = 1'b1; oval_nxt = 1'b1;
        if ((ram_rdata & res_mask) != '0) begin
          ostat_nxt = ST_OVERLAP;
        end else begin
          ostat_nxt = ST_OK;
          ram_we    = 1'b1;
          ram_wdata = ram_rdata | res_mask;
        end
        state_nxt = S_IDLE;
      end

      S_PL_RD: begin
        state_nxt = S_PL_SCAN;
      end

      S_PL_SCAN: begin
        // free run: count free slots from start up to first busy or horizon
        word_nxt = ram_rdata;
        run_nxt  = '0;
        if (SCNT_W'(start_r) < eff_h && !ram_rdata[start_r]) begin
          for (int j = MAX_SLOTS - 1; j >= 0; j--) begin
            if (SCNT_W'(j) >= SCNT_W'(start_r) && (ram_rdata[j] ||
                SCNT_W'(j) >= eff_h)) begin
              run_nxt = SCNT_W'(j) - SCNT_W'(start_r);
            end
          end
          if (!(|(ram_rdata & ~((MAX_SLOTS)'(1) << start_r) &
                ({MAX_SLOTS{1'b1}} << start_r))) &&
              eff_h == SCNT_W'(MAX_SLOTS)) begin
            run_nxt = SCNT_W'(MAX_SLOTS) - SCNT_W'(start_r);
          end
          pfound_nxt = 1'b1;
        end else begin
          pfound_nxt = 1'b0;
        end
        state_nxt = S_PL_MUL;
      end

      S_PL_MUL: begin
        len_nxt   = LEN_W'(run_len * LEN_W'(slot_time_r));
        state_nxt = S_PL_CLASS;
        core_nxt  = core_r;
      end

      S_PL_CLASS: begin
        if (eff_c != '0 && core_r < eff_c) begin
          if (pfound_r) begin
            if ({1'b0, len_r} >= {2'b0, exec_r}) begin
              fit_nxt[core_r[CORE_W-1:0]] = 1'b1;
              nfit_nxt = nfit_r + 1'b1;
            end else if ((SCNT_W+1)'(start_r) + (SCNT_W+1)'(run_r) ==
                         (SCNT_W+1)'(eff_h)) begin
              unc_nxt[core_r[CORE_W-1:0]] = 1'b1;
              nunc_nxt = nunc_r + 1'b1;
            end
          end
          core_nxt = core_r + 1'b1;
        end
        if (eff_c != '0 && core_r + 1'b1 < eff_c) begin
          state_nxt = S_PL_RD;
        end else begin
          k_nxt     = '0;
          spare_nxt = '0;
          pidx_nxt  = '0;
          pfound_nxt = 1'b0;
          if ((CNT_W+1)'(nfit_nxt) + (CNT_W+1)'(nunc_nxt) < (CNT_W+1)'(want_r)) begin
            ocore_nxt = '0; ospare_nxt = '0; ostat_nxt = ST_NOCORES;
            olast_nxt = 1'b1; oval_nxt = 1'b1; state_nxt = S_IDLE;
          end else if (want_r == '0) begin
            ocore_nxt = '0; ospare_nxt = '0; ostat_nxt = ST_OK;
            olast_nxt = 1'b1; oval_nxt = 1'b1; state_nxt = S_IDLE;
          end else begin
            state_nxt = S_PL_PICK;
          end
        end
      end

      S_PL_PICK: begin
        // one core per cycle: shortest unused candidate, ties to lower core
        if (pidx_r < eff_c) begin
          if (((k_r < nfit_r) ? fit_r[pidx_r[CORE_W-1:0]] : unc_r[pidx_r[CORE_W-1:0]]) &&
              !used_r[pidx_r[CORE_W-1:0]] &&
              (!pfound_r || lens_r[pidx_r[CORE_W-1:0]] < pbest_r)) begin
            pfound_nxt = 1'b1;
            pbest_nxt  = lens_r[pidx_r[CORE_W-1:0]];
            pbi_nxt    = pidx_r[CORE_W-1:0];
          end
          pidx_nxt = pidx_r + 1'b1;
        end else begin
          state_nxt = S_OUT;
        end
      end

      S_OUT: begin
        if (!oval_r || out_acc) begin
          used_nxt[pbi_r] = 1'b1;
          ocore_nxt = 4'(pbi_r);
          ostat_nxt = ST_OK;
          if (k_r < nfit_r) begin
            spare_nxt = spare_r + SPARE_W'(pbest_r - LEN_W'(exec_r));
          end
          if (CNT_W'(k_r + 1'b1) == CNT_W'(want_r)) begin
            olast_nxt  = 1'b1;
            ospare_nxt = (k_r < nfit_r) ?
                         SPARE_W'(spare_r + SPARE_W'(pbest_r - LEN_W'(exec_r))) :
                         spare_r;
            state_nxt  = S_IDLE;
          end else begin
            olast_nxt  = 1'b0;
            ospare_nxt = '0;
            state_nxt  = S_PL_PICK;
          end
          oval_nxt   = 1'b1;
          k_nxt      = k_r + 1'b1;
          pidx_nxt   = '0;
          pfound_nxt = 1'b0;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      clr_r     <= 1'b1;
      clr_idx_r <= '0;
      oval_r    <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      clr_r     <= clr_nxt;
      clr_idx_r <= clr_idx_nxt;
      oval_r    <= oval_nxt;
    end
  end

  always_ff @(posedge clk) begin
    start_r  <= start_nxt;
    exec_r   <= exec_nxt;
    want_r   <= want_nxt;
    core_r   <= core_nxt;
    word_r   <= word_nxt;
    run_r    <= run_nxt;
    len_r    <= len_nxt;
    fit_r    <= fit_nxt;
    unc_r    <= unc_nxt;
    used_r   <= used_nxt;
    nfit_r   <= nfit_nxt;
    nunc_r   <= nunc_nxt;
    k_r      <= k_nxt;
    spare_r  <= spare_nxt;
    quo_r    <= quo_nxt;
    rem_r    <= rem_nxt;
    dstep_r  <= dstep_nxt;
    pidx_r   <= pidx_nxt;
    pfound_r <= pfound_nxt;
    pbest_r  <= pbest_nxt;
    pbi_r    <= pbi_nxt;
    ocore_r  <= ocore_nxt;
    ospare_r <= ospare_nxt;
    ostat_r  <= ostat_nxt;
    olast_r  <= olast_nxt;
    if (state_r == S_PL_CLASS && core_r < eff_c) begin
      lens_r[core_r[CORE_W-1:0]] <= len_r;
    end
  end

  assign out_tvalid = oval_r;
  assign out_tdata  = {1'b0, ostat_r, ospare_r, ocore_r};
  assign out_tlast  = olast_r;

endmodule

// ----- rtl/msp_checker.sv -----
// ----------------------------------------------------------------------------
// msp_port_checks
// Port-level checks for the multicore slot placement block.
// ----------------------------------------------------------------------------
module msp_port_checks (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [31:0] out_tdata,
  input logic        out_tlast,
  input logic        cfg_pready
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  a_no_take_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !in_tready)
    else $error("request taken while result pending");

  a_err_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[30:29] != 2'd0 |-> out_tlast)
    else $error("error result not last");

  a_pready: assert property (@(posedge clk) cfg_pready)
    else $error("pready low");

endmodule

bind multicore_slot_placement_core msp_port_checks u_msp_port_checks (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast),
  .cfg_pready (cfg_pready)
);

// ----- tb/msp_checker.sv -----
// ----------------------------------------------------------------------------
// msp_checker
// Watches the request and result streams of the slot placement core, keeps a
// shadow copy of the per-core busy maps and registers, predicts the results
// of every accepted request and compares them in order.
// ----------------------------------------------------------------------------
module msp_checker
  import msp_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [39:0] in_tdata,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [31:0] out_tdata,
  input  logic        out_tlast,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [3:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  input  logic        cfg_pready,
  output int          fail_count,
  output int          pending,
  output int          results_seen
);

  typedef struct packed {
    logic [3:0]  core_id;
    logic [24:0] spare_time;
    logic [1:0]  status;
    logic        last;
  } slot_result_t;

  logic [MAX_SLOTS-1:0] shadow_busy [MAX_CORES];
  logic [4:0]  sh_cores;
  logic [15:0] sh_slot_time;
  logic [5:0]  sh_slots;
  slot_result_t placement_q[$];

  function automatic slot_result_t mk(logic [3:0] c, logic [24:0] sp,
                                      logic [1:0] st, logic l);
    slot_result_t r;
    r.core_id = c; r.spare_time = sp; r.status = st; r.last = l;
    return r;
  endfunction

  function automatic void queue_result(slot_result_t r);
    placement_q.insert(placement_q.size(), r);
  endfunction

  task automatic predict_request(logic [39:0] d);
    logic        act;
    int unsigned s, ex, want, csel, nc, h, n, e, b, nfit, nunc, best;
    longint unsigned spare;
    longint unsigned len [MAX_CORES];
    bit fit [MAX_CORES];
    bit unc [MAX_CORES];
    bit used [MAX_CORES];
    bit clash;
    act  = d[0];
    s    = 32'(d[5:1]);
    ex   = 32'(d[26:6]);
    want = 32'(d[31:27]);
    csel = 32'(d[35:32]);
    nc   = (sh_cores > MAX_CORES) ? MAX_CORES : 32'(sh_cores);
    h    = (sh_slots > MAX_SLOTS) ? MAX_SLOTS : 32'(sh_slots);
    if (act) begin
      if (csel >= nc) begin
        queue_result(mk(0, 0, ST_BADCORE, 1));
        return;
      end
      if (ex == 0) n = 0;
      else if (sh_slot_time == 0) n = MAX_SLOTS;
      else n = (ex + sh_slot_time - 1) / sh_slot_time;
      e = s + n;
      if (e > h) e = h;
      clash = 0;
      for (int j = s; j < e; j++) if (shadow_busy[csel][j]) clash = 1;
      if (clash) begin
        queue_result(mk(0, 0, ST_OVERLAP, 1));
        return;
      end
      for (int j = s; j < e; j++) shadow_busy[csel][j] = 1'b1;
      queue_result(mk(0, 0, ST_OK, 1));
      return;
    end
    if (want > nc) begin
      queue_result(mk(0, 0, ST_NOCORES, 1));
      return;
    end
    nfit = 0; nunc = 0; spare = 0;
    for (int i = 0; i < MAX_CORES; i++) begin
      len[i] = 0; fit[i] = 0; unc[i] = 0; used[i] = 0;
    end
    for (int i = 0; i < nc; i++) begin
      if (s >= h || shadow_busy[i][s]) continue;
      b = s;
      while (b < h && !shadow_busy[i][b]) b++;
      len[i] = longint'(b - s) * sh_slot_time;
      if (len[i] >= ex) begin
        fit[i] = 1; nfit++;
      end else if (b == h) begin
        unc[i] = 1; nunc++;
      end
    end
    if (nfit + nunc < want) begin
      queue_result(mk(0, 0, ST_NOCORES, 1));
      return;
    end
    if (want == 0) begin
      queue_result(mk(0, 0, ST_OK, 1));
      return;
    end
    for (int k = 0; k < want; k++) begin
      best = MAX_CORES;
      for (int i = 0; i < nc; i++) begin
        if (used[i] || !((k < nfit) ? fit[i] : unc[i])) continue;
        if (best == MAX_CORES || len[i] < len[best]) best = i;
      end
      if (best == MAX_CORES) best = 0;
      else begin
        used[best] = 1;
        if (k < nfit) spare += len[best] - ex;
      end
      queue_result(mk(best[3:0], (k == want - 1) ? spare[24:0] : 25'd0,
                      ST_OK, k == want - 1));
    end
  endtask

  slot_result_t got, exp_r;
  always @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < MAX_CORES; i++) shadow_busy[i] = '0;
      sh_cores     <= 5'd16;
      sh_slot_time <= 16'd1;
      sh_slots     <= 6'd32;
      fail_count   <= 0;
      results_seen <= 0;
      placement_q.delete();
    end else begin
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready) begin
        case (cfg_paddr[3:2])
          REG_CORES: sh_cores     <= cfg_pwdata[4:0];
          REG_SLOT:  sh_slot_time <= cfg_pwdata[15:0];
          REG_SLOTS: sh_slots     <= cfg_pwdata[5:0];
          default: ;
        endcase
      end
      if (out_tvalid && out_tready) begin
        results_seen <= results_seen + 1;
        got = mk(out_tdata[3:0], out_tdata[28:4], out_tdata[30:29], out_tlast);
        if (placement_q.size() == 0) begin
          if (fail_count < 10) $display("unexpected result %p", got);
          fail_count <= fail_count + 1;
        end else begin
          exp_r = placement_q.pop_front();
          if (got !== exp_r || out_tdata[31] !== 1'b0) begin
            if (fail_count < 10)
              $display("mismatch: expected %p, got %p", exp_r, got);
            fail_count <= fail_count + 1;
          end
        end
      end
      // requests are predicted after results so pop/push never race
      if (in_tvalid && in_tready) predict_request(in_tdata);
    end
  end

  assign pending = placement_q.size();

endmodule

// ----- tb/tb_multicore_slot_placement_core.sv -----
// ----------------------------------------------------------------------------
// tb_multicore_slot_placement_core
// Drives reserve and place requests through several register settings with
// random stalls on both streams outside one phase; a checker beside the core compares results.
// ----------------------------------------------------------------------------
module tb_multicore_slot_placement_core;
  import msp_pkg::*;

  localparam int IDLE_LIMIT = 20000;

  logic        clk, rst_n;
  logic        in_tvalid, in_tready;
  logic [39:0] in_tdata;
  logic        out_tvalid, out_tready;
  logic [31:0] out_tdata;
  logic        out_tlast;
  logic        cfg_psel, cfg_penable, cfg_pwrite;
  logic [3:0]  cfg_paddr;
  logic [31:0] cfg_pwdata, cfg_prdata;
  logic        cfg_pready;
  int          fail_count, pending, results_seen;
  int          idle_cycles, requests_sent;
  bit          no_stall;

  multicore_slot_placement_core u_dut (.*);

  msp_checker u_chk (.*);

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  // result side back-pressure
  always @(posedge clk) begin
    out_tready <= no_stall || ($urandom_range(99) >= 31);
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > IDLE_LIMIT) begin
      $display("tb_multicore_slot_placement_core failed");
      $finish;
    end
  end

  task automatic write_reg(logic [1:0] idx, logic [31:0] val);
    cfg_psel <= 1; cfg_penable <= 0; cfg_pwrite <= 1;
    cfg_paddr <= {idx, 2'b00}; cfg_pwdata <= val;
    @(posedge clk);
    cfg_penable <= 1;
    @(posedge clk);
    cfg_psel <= 0; cfg_penable <= 0; cfg_pwrite <= 0;
    @(posedge clk);
  endtask

  task automatic send_request(logic act, logic [4:0] s, logic [20:0] ex,
                              logic [4:0] want, logic [3:0] csel);
    while (!no_stall && $urandom_range(99) < 31) begin
      in_tvalid <= 0;
      @(posedge clk);
    end
    in_tvalid <= 1;
    in_tdata  <= {4'd0, csel, want, ex, s, act};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    requests_sent++;
  endtask

  task automatic drain();
    in_tvalid <= 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (400) @(posedge clk);
  endtask

  task automatic set_regs(logic [4:0] c, logic [15:0] st, logic [5:0] h);
    drain();
    write_reg(REG_CORES, 32'(c));
    write_reg(REG_SLOT, 32'(st));
    write_reg(REG_SLOTS, 32'(h));
  endtask

  task automatic random_phase(int count, int tmax);
    logic [20:0] ex;
    for (int i = 0; i < count; i++) begin
      case ($urandom_range(9))
        0:       ex = 21'($urandom);
        1:       ex = 0;
        default: ex = 21'($urandom_range(tmax));
      endcase
      // mostly reserves to build up a map, mixed with places against it
      if ($urandom_range(99) < 55)
        send_request(1, 5'($urandom), ex, 5'($urandom),
                     4'($urandom_range(17) % 16));
      else
        send_request(0, 5'($urandom), ex, ($urandom_range(99) < 85) ?
                     5'($urandom_range(6)) : 5'($urandom), 4'($urandom));
    end
  endtask

  initial begin
    rst_n = 0; in_tvalid = 0; in_tdata = '0;
    cfg_psel = 0; cfg_penable = 0; cfg_pwrite = 0; cfg_paddr = '0;
    cfg_pwdata = '0; no_stall = 0; requests_sent = 0;
    repeat (7) @(posedge clk);
    rst_n <= 1;
    repeat (20) @(posedge clk);
    // directed: extremes under reset settings
    send_request(0, 0, 0, 0, 0);
    send_request(0, 0, 21'h1FFFFF, 16, 0);
    send_request(0, 5, 3, 17, 0);
    send_request(1, 0, 4, 0, 15);
    send_request(1, 2, 1, 0, 15);
    send_request(1, 31, 21'h1FFFFF, 31, 3);
    send_request(1, 10, 0, 0, 2);
    send_request(0, 0, 2, 16, 15);
    send_request(0, 4, 28, 3, 0);
    send_request(0, 31, 1, 16, 0);
    set_regs(5'd3, 16'hFFFF, 6'd40);
    send_request(1, 0, 21'h1FFFFF, 0, 3);
    send_request(1, 0, 21'h1FFFFF, 0, 1);
    send_request(0, 0, 21'h1FFFFF, 3, 0);
    send_request(0, 1, 21'd70000, 2, 0);
    set_regs(5'd0, 16'd0, 6'd0);
    send_request(1, 0, 5, 0, 0);
    send_request(0, 0, 5, 0, 0);
    set_regs(5'd31, 16'd0, 6'd63);
    send_request(1, 3, 1, 0, 7);
    send_request(1, 0, 0, 0, 8);
    send_request(0, 0, 0, 16, 0);
    send_request(0, 31, 21'h1FFFFF, 5, 0);
    // random phases over several settings
    set_regs(5'd16, 16'd1, 6'd32);
    random_phase(140, 40);
    set_regs(5'd4, 16'd7, 6'd12);
    no_stall = 1;
    random_phase(90, 100);
    no_stall = 0;
    set_regs(5'd1, 16'd1, 6'd1);
    random_phase(40, 3);
    set_regs(5'd16, 16'd65535, 6'd32);
    random_phase(80, 2097120);
    set_regs(5'($urandom_range(1, 16)), 16'($urandom_range(1, 50)),
             6'($urandom_range(1, 32)));
    random_phase(90, 600);
    drain();
    $display("%0d requests sent over nine register settings, %0d results checked",
             requests_sent, results_seen);
    if (fail_count == 0)
      $display("tb_multicore_slot_placement_core passed");
    else
      $display("tb_multicore_slot_placement_core failed");
    $finish;
  end

endmodule

// ----- multicore_slot_placement_core.f -----
rtl/msp_pkg.sv
rtl/msp_ram.sv
rtl/multicore_slot_placement_core.sv
rtl/msp_checker.sv
tb/msp_checker.sv
tb/tb_multicore_slot_placement_core.sv
